// ===== rtl/core/uer_pkg.sv =====
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
`default_nettype none

package uer_pkg;

  // counter and register widths
  localparam int unsigned CNT_W   = 24;
  localparam int unsigned ECHO_W  = 16;
  localparam int unsigned TRIG_W  = 8;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // echo counter wraps to zero after this count
  localparam logic [ECHO_W-1:0] ECHO_WRAP = 16'd65534;
  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};

  // register reset values
  localparam logic [TRIG_W-1:0]  TRIG_WIDTH_RST = 8'd20;
  localparam logic [CNT_W-1:0]   PACE_RST       = 24'd100000;
  localparam logic [CNT_W-1:0]   TIMEOUT_RST    = 24'd1500000;
  localparam logic [SCALE_W-1:0] SCALE_RST      = 16'd1114;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_WIDTH = 2'd0,
    REG_PACE       = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_SCALE      = 2'd3
  } cfg_idx_t;

  // configuration values seen by the core
  typedef struct packed {
    logic [TRIG_W-1:0]  trigger_width;
    logic [CNT_W-1:0]   pace_interval;
    logic [CNT_W-1:0]   echo_timeout;
    logic [SCALE_W-1:0] distance_scale;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/uer_cfg_regs.sv =====
// configuration register file of the ultrasonic echo ranger
// depends on uer_pkg for register indexes, widths and reset values
`default_nettype none

module uer_cfg_regs
  import uer_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  cfg_t cfg_r, cfg_nxt;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // decode the write beat
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_TRIG_WIDTH: cfg_nxt.trigger_width  = cfg_data[TRIG_W-1:0];
        REG_PACE:       cfg_nxt.pace_interval  = cfg_data[CNT_W-1:0];
        REG_TIMEOUT:    cfg_nxt.echo_timeout   = cfg_data[CNT_W-1:0];
        REG_SCALE:      cfg_nxt.distance_scale = cfg_data[SCALE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_width  <= TRIG_WIDTH_RST;
      cfg_r.pace_interval  <= PACE_RST;
      cfg_r.echo_timeout   <= TIMEOUT_RST;
      cfg_r.distance_scale <= SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/core/uer_in_stage.sv =====
// input register of the ultrasonic echo ranger: holds one echo sample beat
// depends on uer_pkg only by convention; no types used beyond logic
`default_nettype none

module uer_in_stage
  import uer_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic in_echo_level,
  input  wire logic take,
  output logic      s1_valid,
  output logic      s1_level
);

  logic s1_valid_r, s1_valid_nxt;
  logic s1_level_r, s1_level_nxt;

  // room when empty or when the held beat moves on this cycle
  assign in_ready = !s1_valid_r || take;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_level_nxt = s1_level_r;
    if (take) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
      s1_level_nxt = in_echo_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // sample bit needs no reset
  always_ff @(posedge clk) begin
    s1_level_r <= s1_level_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_level = s1_level_r;

endmodule

`default_nettype wire

// ===== rtl/core/uer_core.sv =====
// tick update and result register of the ultrasonic echo ranger
// depends on uer_pkg for cfg_t, widths and the echo wrap count
`default_nettype none

module uer_core
  import uer_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  cfg_t                    cfg,
  input  wire logic               s1_valid,
  input  wire logic               s1_level,
  output logic                    take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_trigger_level,
  output logic                    out_busy_res,
  output logic                    out_result_valid,
  output logic                    out_timed_out,
  output logic [ECHO_W-1:0]       out_echo_time_us,
  output logic [DIST_W-1:0]       out_distance_q16
);

  // ranging state
  logic              echo_prev_r, echo_prev_nxt;
  logic              await_fall_r, await_fall_nxt;
  logic [ECHO_W-1:0] echo_cnt_r, echo_cnt_nxt;
  logic              in_flight_r, in_flight_nxt;
  logic [TRIG_W-1:0] trig_left_r, trig_left_nxt;
  logic [CNT_W-1:0]  pace_cnt_r, pace_cnt_nxt;
  logic [CNT_W-1:0]  since_trig_r, since_trig_nxt;
  logic [ECHO_W-1:0] last_time_r, last_time_nxt;
  logic [DIST_W-1:0] last_dist_r, last_dist_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic trig_r, trig_nxt;
  logic done_r, done_nxt;
  logic tout_r, tout_nxt;

  // the held beat is processed when the result register can load
  assign take = s1_valid && (!out_valid_r || out_ready);

  // one tick of the ranger
  always_comb begin
    echo_prev_nxt  = echo_prev_r;
    await_fall_nxt = await_fall_r;
    echo_cnt_nxt   = echo_cnt_r;
    in_flight_nxt  = in_flight_r;
    trig_left_nxt  = trig_left_r;
    pace_cnt_nxt   = pace_cnt_r;
    since_trig_nxt = since_trig_r;
    last_time_nxt  = last_time_r;
    last_dist_nxt  = last_dist_r;
    trig_nxt       = 1'b0;
    done_nxt       = 1'b0;
    tout_nxt       = 1'b0;

    if (take) begin
      // free-running counters
      echo_cnt_nxt   = (echo_cnt_r >= ECHO_WRAP) ? '0 : echo_cnt_r + 1'b1;
      pace_cnt_nxt   = (pace_cnt_r == CNT_MAX) ? CNT_MAX : pace_cnt_r + 1'b1;
      since_trig_nxt = (since_trig_r == CNT_MAX) ? CNT_MAX : since_trig_r + 1'b1;

      // pacing decision: launch or abandon
      if (pace_cnt_nxt > cfg.pace_interval) begin
        if (!in_flight_r) begin
          trig_left_nxt  = cfg.trigger_width;
          since_trig_nxt = '0;
          in_flight_nxt  = 1'b1;
        end else if (since_trig_nxt > cfg.echo_timeout) begin
          in_flight_nxt = 1'b0;
          tout_nxt      = 1'b1;
        end
        pace_cnt_nxt = '0;
      end

      // trigger pulse
      if (trig_left_nxt != '0) begin
        trig_nxt      = 1'b1;
        trig_left_nxt = trig_left_nxt - 1'b1;
      end

      // echo edges
      if (!await_fall_r) begin
        if (!echo_prev_r && s1_level) begin
          echo_cnt_nxt   = '0;
          await_fall_nxt = 1'b1;
        end
      end else if (echo_prev_r && !s1_level) begin
        last_time_nxt  = echo_cnt_nxt;
        last_dist_nxt  = {{(DIST_W-ECHO_W){1'b0}}, echo_cnt_nxt}
                       * {{(DIST_W-SCALE_W){1'b0}}, cfg.distance_scale};
        await_fall_nxt = 1'b0;
        in_flight_nxt  = 1'b0;
        done_nxt       = 1'b1;
      end
      echo_prev_nxt = s1_level;
    end
  end

  // result beat occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_prev_r  <= 1'b0;
      await_fall_r <= 1'b0;
      echo_cnt_r   <= '0;
      in_flight_r  <= 1'b0;
      trig_left_r  <= '0;
      pace_cnt_r   <= '0;
      since_trig_r <= '0;
      last_time_r  <= '0;
      last_dist_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      echo_prev_r  <= echo_prev_nxt;
      await_fall_r <= await_fall_nxt;
      echo_cnt_r   <= echo_cnt_nxt;
      in_flight_r  <= in_flight_nxt;
      trig_left_r  <= trig_left_nxt;
      pace_cnt_r   <= pace_cnt_nxt;
      since_trig_r <= since_trig_nxt;
      last_time_r  <= last_time_nxt;
      last_dist_r  <= last_dist_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // per-beat flags load only with a new result
  always_ff @(posedge clk) begin
    if (take) begin
      trig_r <= trig_nxt;
      done_r <= done_nxt;
      tout_r <= tout_nxt;
    end
  end

  // held values change only when a new result loads, so they drive the beat
  assign out_valid         = out_valid_r;
  assign out_trigger_level = trig_r;
  assign out_busy_res      = in_flight_r;
  assign out_result_valid  = done_r;
  assign out_timed_out     = tout_r;
  assign out_echo_time_us  = last_time_r;
  assign out_distance_q16  = last_dist_r;

endmodule

`default_nettype wire

// ===== rtl/core/ultrasonic_echo_ranger.sv =====
// Ultrasonic echo ranger: feed one beat per microsecond tick carrying the sampled
// echo pin level; every input beat yields exactly one result beat with the trigger
// pin drive, the busy flag, result and timeout strobes, and the last echo time and
// Q16 distance in centimetres. One beat is taken every clock cycle while out_ready
// is high; a held result beat stalls in_ready in the same cycle once the input
// register is full. The input register loads on acceptance; the combinational tick
// update, with its 16x16 multiply, loads the result register when the held beat
// is taken. Configuration registers (0 trigger width, 1 pace interval, 2 echo
// timeout, 3 distance scale) are written through the always-ready cfg port; the
// user must write them only while idle; the block itself does not enforce it.
// depends on uer_pkg, uer_cfg_regs, uer_in_stage and uer_core
`default_nettype none

module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_echo_level,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_trigger_level,
  output logic                       out_busy_res,
  output logic                       out_result_valid,
  output logic                       out_timed_out,
  output logic [ECHO_W-1:0]          out_echo_time_us,
  output logic [DIST_W-1:0]          out_distance_q16,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;
  logic s1_valid;
  logic s1_level;
  logic take;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_in_stage u_in (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_echo_level (in_echo_level),
    .take          (take),
    .s1_valid      (s1_valid),
    .s1_level      (s1_level)
  );

  uer_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .s1_valid          (s1_valid),
    .s1_level          (s1_level),
    .take              (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_busy_res      (out_busy_res),
    .out_result_valid  (out_result_valid),
    .out_timed_out     (out_timed_out),
    .out_echo_time_us  (out_echo_time_us),
    .out_distance_q16  (out_distance_q16)
  );

endmodule

`default_nettype wire

// ===== rtl/core/uer_checker.sv =====
// port-level checks for the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg for widths and on ultrasonic_echo_ranger for the bind
`default_nettype none

module uer_checker
  import uer_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_busy_res,
  input wire logic              out_result_valid,
  input wire logic              out_timed_out,
  input wire logic [ECHO_W-1:0] out_echo_time_us,
  input wire logic [DIST_W-1:0] out_distance_q16
);

  // no result beat straight out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_echo_time_us)
                                   && $stable(out_distance_q16)))
    else $error("stalled result beat changed");

  // a latched echo ends the measurement
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_valid) |-> !out_busy_res)
    else $error("busy after a latched echo");

  // an abandoned measurement is no longer busy
  a_timeout_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_timed_out) |-> !out_busy_res)
    else $error("busy after a timeout");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_busy_res     (out_busy_res),
  .out_result_valid (out_result_valid),
  .out_timed_out    (out_timed_out),
  .out_echo_time_us (out_echo_time_us),
  .out_distance_q16 (out_distance_q16)
);

`default_nettype wire
